>>> rtl/ylc_pkg.sv
// Package for the luma-curve pixel core: stage payload types and the
// BT.601 integer coefficients. No dependencies.
`default_nettype none

package ylc_pkg;

    // Width of the signed accumulators used by both color transforms.
    localparam int SUM_W = 19;

    // Forward transform coefficients.
    localparam logic signed [SUM_W-1:0] K_YR = 19'sd66;
    localparam logic signed [SUM_W-1:0] K_YG = 19'sd129;
    localparam logic signed [SUM_W-1:0] K_YB = 19'sd25;
    localparam logic signed [SUM_W-1:0] K_UR = -19'sd38;
    localparam logic signed [SUM_W-1:0] K_UG = -19'sd74;
    localparam logic signed [SUM_W-1:0] K_UB = 19'sd112;
    localparam logic signed [SUM_W-1:0] K_VR = 19'sd112;
    localparam logic signed [SUM_W-1:0] K_VG = -19'sd94;
    localparam logic signed [SUM_W-1:0] K_VB = -19'sd18;

    // Inverse transform coefficients.
    localparam logic signed [SUM_W-1:0] K_C  = 19'sd298;
    localparam logic signed [SUM_W-1:0] K_RE = 19'sd409;
    localparam logic signed [SUM_W-1:0] K_GD = -19'sd100;
    localparam logic signed [SUM_W-1:0] K_GE = -19'sd208;
    localparam logic signed [SUM_W-1:0] K_BD = 19'sd516;

    // Rounding term added before every shift by eight.
    localparam logic signed [SUM_W-1:0] K_RND = 19'sd128;

    // Luma offset added after the forward transform and removed before the inverse one.
    localparam logic signed [9:0] LUMA_OFS = 10'sd16;
    localparam logic [7:0] Y_OFS = 8'd16;

    // Action codes of an input beat.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    // Payload leaving the forward transform stage.
    typedef struct packed {
        logic       action;
        logic [7:0] luma;
        logic [7:0] d;      // U - 128, two's complement
        logic [7:0] e;      // V - 128, two's complement
        logic [7:0] curve_index;
        logic [7:0] curve_value;
        logic       last;
    } fwd_t;

    // Payload leaving the curve lookup stage (pixels only).
    typedef struct packed {
        logic [7:0] curve_data;
        logic       hit;    // entry has been written since reset
        logic [7:0] luma;
        logic [7:0] d;
        logic [7:0] e;
        logic       last;
    } lut_t;

endpackage

`default_nettype wire

>>> rtl/ylc_fwd_stage.sv
// Forward RGB to Y'UV stage of the luma-curve pixel core, one register stage.
// Depends on ylc_pkg.
`default_nettype none

module ylc_fwd_stage import ylc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       action,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    input  wire logic [7:0] curve_index,
    input  wire logic [7:0] curve_value,
    input  wire logic       last_pixel,
    output logic            out_valid,
    input  wire logic       out_ready,
    output fwd_t            out_data
);

    logic signed [SUM_W-1:0] r_w, g_w, b_w;
    logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;
    logic                    valid_reg;
    fwd_t                    data_reg;
    fwd_t                    data_next;

    // The stage takes a beat whenever its register is empty or draining.
    assign in_ready = !valid_reg || out_ready;

    // Weighted sums; the shift by eight is a bit select (floor for negatives).
    always_comb begin
        r_w   = {11'b0, red};
        g_w   = {11'b0, green};
        b_w   = {11'b0, blue};
        y_sum = K_YR * r_w + K_YG * g_w + K_YB * b_w + K_RND;
        u_sum = K_UR * r_w + K_UG * g_w + K_UB * b_w + K_RND;
        v_sum = K_VR * r_w + K_VG * g_w + K_VB * b_w + K_RND;

        data_next.action      = action;
        data_next.luma        = y_sum[15:8] + Y_OFS;
        data_next.d           = u_sum[15:8];
        data_next.e           = v_sum[15:8];
        data_next.curve_index = curve_index;
        data_next.curve_value = curve_value;
        data_next.last        = last_pixel;
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/ylc_curve_store.sv
// Luminance curve memory with per-entry written flags and the lookup stage.
// Depends on ylc_pkg.
`default_nettype none

module ylc_curve_store import ylc_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire fwd_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output lut_t      out_data
);

    logic [7:0]   curve_mem [256];
    logic [255:0] written_reg;
    logic         valid_reg;
    lut_t         data_reg;
    logic         adv;
    logic         is_load;

    assign in_ready = !valid_reg || out_ready;
    assign adv      = in_valid && in_ready;
    assign is_load  = (in_data.action == ACT_LOAD);

    // Load beats write the memory; pixel beats read it. Both happen as the
    // beat passes this stage, so accesses stay in arrival order. The pixel
    // side-band fields travel with the read data.
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (is_load) begin
                curve_mem[in_data.curve_index] <= in_data.curve_value;
            end else begin
                data_reg.curve_data <= curve_mem[in_data.luma];
                data_reg.hit        <= written_reg[in_data.luma];
                data_reg.luma       <= in_data.luma;
                data_reg.d          <= in_data.d;
                data_reg.e          <= in_data.e;
                data_reg.last       <= in_data.last;
            end
        end
    end

    // Written flags: an unwritten entry reads as its own index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (adv && is_load) begin
            written_reg[in_data.curve_index] <= 1'b1;
        end
    end

    // Load beats end here and leave no result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid && !is_load;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/ylc_inv_stage.sv
// Inverse Y'UV to RGB transform: an accumulate stage and a clamp/output stage.
// Depends on ylc_pkg.
`default_nettype none

module ylc_inv_stage import ylc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire lut_t       in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic            last
);

    logic [7:0]              luma_sel;
    logic signed [9:0]       c_narrow;
    logic signed [SUM_W-1:0] c_w, d_w, e_w;
    logic signed [SUM_W-1:0] r_sum_next, g_sum_next, b_sum_next;
    logic signed [SUM_W-1:0] r_sum_reg, g_sum_reg, b_sum_reg;
    logic                    last_acc_reg;
    logic                    acc_valid_reg;
    logic                    acc_ready;
    logic                    out_valid_reg;
    logic [7:0]              red_reg, green_reg, blue_reg;
    logic                    last_reg;
    logic [7:0]              red_next, green_next, blue_next;

    // Floor shift by eight, then clamp to 0..255.
    function automatic logic [7:0] clamp_shift(input logic signed [SUM_W-1:0] s);
        logic [10:0] q;
        q = s[18:8];
        if (q[10]) begin
            clamp_shift = 8'd0;
        end else if (|q[9:8]) begin
            clamp_shift = 8'd255;
        end else begin
            clamp_shift = q[7:0];
        end
    endfunction

    assign acc_ready = !out_valid_reg || out_ready;
    assign in_ready  = !acc_valid_reg || acc_ready;

    // Pick the remapped luma and form the three weighted sums.
    always_comb begin
        luma_sel   = in_data.hit ? in_data.curve_data : in_data.luma;
        c_narrow   = $signed({2'b00, luma_sel}) - LUMA_OFS;
        c_w        = SUM_W'(c_narrow);
        d_w        = SUM_W'($signed(in_data.d));
        e_w        = SUM_W'($signed(in_data.e));
        r_sum_next = K_C * c_w + K_RE * e_w + K_RND;
        g_sum_next = K_C * c_w + K_GD * d_w + K_GE * e_w + K_RND;
        b_sum_next = K_C * c_w + K_BD * d_w + K_RND;
    end

    // Accumulate stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= 1'b0;
        end else if (in_ready) begin
            acc_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            r_sum_reg    <= r_sum_next;
            g_sum_reg    <= g_sum_next;
            b_sum_reg    <= b_sum_next;
            last_acc_reg <= in_data.last;
        end
    end

    // Clamp and output register.
    always_comb begin
        red_next   = clamp_shift(r_sum_reg);
        green_next = clamp_shift(g_sum_reg);
        blue_next  = clamp_shift(b_sum_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (acc_ready) begin
            out_valid_reg <= acc_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_ready && acc_valid_reg) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            last_reg  <= last_acc_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

>>> rtl/yuv_luma_curve_pixel_core.sv
// Top level of the luma-curve pixel core: RGB -> Y'UV -> curve -> RGB.
// Depends on ylc_pkg, ylc_fwd_stage, ylc_curve_store and ylc_inv_stage.
//
//   Channel | Direction | Ports
//   --------+-----------+---------------------------------------------------
//   s_      | in        | s_valid/s_ready, action, RGB, curve entry, last flag
//   m_      | out       | m_valid/m_ready, remapped RGB, last flag
//
// One beat enters per cycle unless m_ready stalls the output; a pixel passes
// through the four register stages (forward transform,
// curve memory read, inverse accumulate, clamp/output). Load beats write the
// curve as they pass the memory stage and produce nothing. Reset empties the
// stages and clears the written flags, so the curve reads as identity at once.
// Each stage holds its beat while the next one is full, so bubbles close up.
`default_nettype none

module yuv_luma_curve_pixel_core import ylc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_action,
    input  wire logic [7:0] s_red_in,
    input  wire logic [7:0] s_green_in,
    input  wire logic [7:0] s_blue_in,
    input  wire logic [7:0] s_curve_index,
    input  wire logic [7:0] s_curve_value,
    input  wire logic       s_last_pixel,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_red_out,
    output logic [7:0]      m_green_out,
    output logic [7:0]      m_blue_out,
    output logic            m_last_out
);

    logic fwd_valid, fwd_ready;
    fwd_t fwd_data;
    logic lut_valid, lut_ready;
    lut_t lut_data;

    // Forward transform.
    ylc_fwd_stage u_fwd (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .action      (s_action),
        .red         (s_red_in),
        .green       (s_green_in),
        .blue        (s_blue_in),
        .curve_index (s_curve_index),
        .curve_value (s_curve_value),
        .last_pixel  (s_last_pixel),
        .out_valid   (fwd_valid),
        .out_ready   (fwd_ready),
        .out_data    (fwd_data)
    );

    // Curve memory and lookup.
    ylc_curve_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fwd_valid),
        .in_ready  (fwd_ready),
        .in_data   (fwd_data),
        .out_valid (lut_valid),
        .out_ready (lut_ready),
        .out_data  (lut_data)
    );

    // Inverse transform and output register.
    ylc_inv_stage u_inv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lut_valid),
        .in_ready  (lut_ready),
        .in_data   (lut_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .red       (m_red_out),
        .green     (m_green_out),
        .blue      (m_blue_out),
        .last      (m_last_out)
    );

endmodule

`default_nettype wire

>>> bench/ylc_pixel_checker.sv
// Checker for the luma-curve pixel core: predicts the remapped RGB of every pixel beat.
// It keeps its own copy of the luma curve and compares each output beat in order.
// Depends on ylc_pkg for the action codes.
`timescale 1ns / 100ps

module ylc_pixel_checker import ylc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_red_in,
    input  logic [7:0] s_green_in,
    input  logic [7:0] s_blue_in,
    input  logic [7:0] s_curve_index,
    input  logic [7:0] s_curve_value,
    input  logic       s_last_pixel,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_red_out,
    input  logic [7:0] m_green_out,
    input  logic [7:0] m_blue_out,
    input  logic       m_last_out,
    output int         mismatches,
    output int         outstanding
);

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } rgb_pixel_t;

    // Shadow of the curve store and the pixels still owed by the core.
    logic [7:0] curve_copy [256];
    rgb_pixel_t owed_pixels [$];
    int         pixel_number;

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        pixel_number = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [7:0] sat8(input int x);
        if (x < 0) return 8'd0;
        if (x > 255) return 8'd255;
        return x[7:0];
    endfunction

    // Forward BT.601 transform, luma lookup in the shadow curve, inverse transform.
    // All terms are plain ints, so >>> is a floor shift on negative sums.
    function automatic rgb_pixel_t remap_pixel(input logic [7:0] r8, input logic [7:0] g8,
                                               input logic [7:0] b8, input logic last);
        int r, g, b, y, u, v, c, d, e;
        rgb_pixel_t p;
        r = r8;
        g = g8;
        b = b8;
        y = ((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16;
        u = ((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128;
        v = ((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128;
        c = int'(curve_copy[y[7:0]]) - 16;
        d = u - 128;
        e = v - 128;
        p.red   = sat8((298 * c + 409 * e + 128) >>> 8);
        p.green = sat8((298 * c - 100 * d - 208 * e + 128) >>> 8);
        p.blue  = sat8((298 * c + 516 * d + 128) >>> 8);
        p.last  = last;
        return p;
    endfunction

    // Output beats are compared before the input beat of the same edge is taken in,
    // since a pixel cannot leave in the cycle it enters.
    always @(posedge aclk) begin
        rgb_pixel_t want;
        if (!aresetn) begin
            for (int i = 0; i < 256; i++) curve_copy[i] = i[7:0];
            owed_pixels.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_pixels.size() == 0) begin
                    report_mismatch($sformatf("output beat with no pixel owed (rgb %0d %0d %0d)",
                                              m_red_out, m_green_out, m_blue_out));
                end else begin
                    want = owed_pixels.pop_front();
                    if (m_red_out !== want.red)
                        report_mismatch($sformatf("pixel %0d red_out %0d, expected %0d",
                                                  pixel_number, m_red_out, want.red));
                    if (m_green_out !== want.green)
                        report_mismatch($sformatf("pixel %0d green_out %0d, expected %0d",
                                                  pixel_number, m_green_out, want.green));
                    if (m_blue_out !== want.blue)
                        report_mismatch($sformatf("pixel %0d blue_out %0d, expected %0d",
                                                  pixel_number, m_blue_out, want.blue));
                    if (m_last_out !== want.last)
                        report_mismatch($sformatf("pixel %0d last_out %b, expected %b",
                                                  pixel_number, m_last_out, want.last));
                end
                pixel_number++;
            end
            if (s_valid && s_ready) begin
                if (s_action == ACT_LOAD)
                    curve_copy[s_curve_index] = s_curve_value;
                else
                    owed_pixels.push_back(remap_pixel(s_red_in, s_green_in, s_blue_in,
                                                      s_last_pixel));
            end
        end
        outstanding <= owed_pixels.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the luma-curve pixel core bench: clock, reset, stimulus and verdict.
// Depends on ylc_pkg, yuv_luma_curve_pixel_core and ylc_pixel_checker.
`timescale 1ns / 100ps

module testbench import ylc_pkg::*;;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 60;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic       s_valid       = 1'b0;
    logic       s_action      = ACT_PIXEL;
    logic [7:0] s_red_in      = 8'd0;
    logic [7:0] s_green_in    = 8'd0;
    logic [7:0] s_blue_in     = 8'd0;
    logic [7:0] s_curve_index = 8'd0;
    logic [7:0] s_curve_value = 8'd0;
    logic       s_last_pixel  = 1'b0;
    logic       m_ready       = 1'b0;

    wire logic       s_ready;
    wire logic       m_valid;
    wire logic [7:0] m_red_out;
    wire logic [7:0] m_green_out;
    wire logic [7:0] m_blue_out;
    wire logic       m_last_out;

    int mismatches;
    int outstanding;

    // Random idle bursts on both channels, switched off for the closing phase.
    bit idles_enabled = 1'b1;
    bit long_stall_go = 1'b0;
    int unsigned cycle_count = 0;

    always #4 aclk = ~aclk;

    yuv_luma_curve_pixel_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_red_in      (s_red_in),
        .s_green_in    (s_green_in),
        .s_blue_in     (s_blue_in),
        .s_curve_index (s_curve_index),
        .s_curve_value (s_curve_value),
        .s_last_pixel  (s_last_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out),
        .m_last_out    (m_last_out)
    );

    ylc_pixel_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_red_in      (s_red_in),
        .s_green_in    (s_green_in),
        .s_blue_in     (s_blue_in),
        .s_curve_index (s_curve_index),
        .s_curve_value (s_curve_value),
        .s_last_pixel  (s_last_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out),
        .m_last_out    (m_last_out),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Offer one beat, maybe after a short idle gap, and hold it until it is taken.
    task automatic offer_beat(input logic act, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] idx,
                              input logic [7:0] val, input logic last);
        int gap;
        if (idles_enabled && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_action      <= act;
        s_red_in      <= r;
        s_green_in    <= g;
        s_blue_in     <= b;
        s_curve_index <= idx;
        s_curve_value <= val;
        s_last_pixel  <= last;
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Pixel beat with random curve fields, which the core must ignore.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic last);
        offer_beat(ACT_PIXEL, r, g, b, 8'($urandom), 8'($urandom), last);
    endtask

    // Curve load beat with random pixel fields, which the core must ignore.
    task automatic send_load(input logic [7:0] idx, input logic [7:0] val);
        offer_beat(ACT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), idx, val,
                   1'($urandom));
    endtask

    // Color levels lean toward the extremes so that the output clamps are hit often.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_item(input int load_pct);
        if ($urandom_range(0, 99) < load_pct)
            send_load(8'($urandom), 8'($urandom));
        else
            send_pixel(pick_level(), pick_level(), pick_level(), 1'($urandom));
    endtask

    // Stop offering and wait until every owed pixel has come out.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Result side: random short stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (long_stall_go) begin
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                long_stall_go = 1'b0;
                m_ready <= 1'b1;
            end else if (idles_enabled && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int x;
        int gray_y;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: primaries, secondaries, black, white and mid gray.
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);

        // Directed: curve remaps to the luma extremes, the first two each read right after its load.
        send_load(8'd16, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_load(8'd235, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_load(8'd0, 8'd255);
        send_load(8'd255, 8'd0);
        send_load(8'd16, 8'd16);
        send_load(8'd235, 8'd235);

        // Directed: ignored fields at their maximum on both kinds of beat.
        offer_beat(ACT_PIXEL, 8'd10, 8'd200, 8'd90, 8'hFF, 8'hFF, 1'b1);
        offer_beat(ACT_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'd128, 8'd77, 1'b1);
        send_pixel(8'd130, 8'd130, 8'd130, 1'b0);
        wait_for_results();

        // Mixed pixels and loads over a mostly identity curve.
        for (int i = 0; i < 400; i++) send_random_item(15);

        // The result side holds off while pixels keep coming, so the core backs up.
        long_stall_go = 1'b1;
        for (int i = 0; i < 40; i++)
            send_pixel(pick_level(), pick_level(), pick_level(), 1'($urandom));

        // Load an entry and read it at once with a gray pixel whose luma hits it,
        // mixed with unrelated beats.
        for (int i = 0; i < 240; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                x = $urandom_range(0, 255);
                gray_y = ((220 * x + 128) >> 8) + 16;
                send_load(8'(gray_y), 8'($urandom));
                send_pixel(8'(x), 8'(x), 8'(x), 1'($urandom));
            end else begin
                send_random_item(30);
            end
        end

        // The sender pauses until the core has returned every pixel.
        wait_for_results();

        // Rewrite the whole curve, then run pixels through it.
        for (int i = 0; i < 256; i++) send_load(8'(i), 8'($urandom));
        for (int i = 0; i < 400; i++) send_random_item(10);

        // Closing phase at full rate on both sides.
        idles_enabled = 1'b0;
        for (int i = 0; i < 420; i++) send_random_item(10);

        wait_for_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
